// ===== sv/ile_pkg.sv =====
package ile_pkg;

    localparam int LIST_CAP = 256;
    localparam int SLOT_W   = $clog2(LIST_CAP);
    localparam int CNT_W    = $clog2(LIST_CAP + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 4;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_APPEND    = 4'd0;
    localparam logic [OP_W-1:0] OP_PREPEND   = 4'd1;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 4'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 4'd3;
    localparam logic [OP_W-1:0] OP_GET       = 4'd4;
    localparam logic [OP_W-1:0] OP_SET       = 4'd5;
    localparam logic [OP_W-1:0] OP_INSERT    = 4'd6;
    localparam logic [OP_W-1:0] OP_DELETE_AT = 4'd7;
    localparam logic [OP_W-1:0] OP_REVERSE   = 4'd8;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADIDX = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [CNT_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] last_value;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_WALK, S_POP_RD, S_POP_TAKE, S_APPEND, S_PREPEND,
        S_INS_A, S_INS_B, S_DELF, S_DELL, S_DM_A, S_DM_B, S_GET_A, S_GET_B,
        S_SET, S_REV, S_REV_END, S_RDH, S_RDT, S_RDE, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        U_NONE, U_LATCH, U_SETUP, U_STEP, U_POP_RD, U_POP_TAKE, U_APPEND,
        U_PREPEND, U_INS_A, U_INS_B, U_DELF, U_DELL, U_DM_A, U_DM_B,
        U_GET_A, U_GET_B, U_SET, U_REV, U_REV_END, U_RDH, U_RDT, U_RDE, U_EMIT
    } t_uop;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic            walk_done;
        logic            rev_last;
        logic            pos_zero;
        logic            pos_eq_len;
        logic            pos_last;
        logic            len_one;
        logic            len_lt2;
        logic            out_free;
    } t_dp_sts;

endpackage

// ===== sv/indexed_list_engine.sv =====
// Singly linked list engine with room for 256 signed 32-bit values.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one request:
// op, position and item_value. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns exactly one transaction per request: status, value
// read, count after the request, and head and tail values.
// One request is in work at a time; o_in_ready is high only when idle.
// Rejected requests, unused ops and a reverse of fewer than two elements
// skip straight to the result read-out. Get and set walk position links,
// insert and delete at an index walk position - 1, delete last walks
// count - 2, and reverse walks the whole list, all at one link memory read
// per cycle. The next request is accepted in the cycle after a result is
// loaded, so a new request is never taken before the last one is through.
// A finished result sits in the output register; the next request is
// accepted while it waits, but its own result holds until the output
// register is taken, so a stalled receiver stops the engine after one request.
// Reset empties the list and restores the free slot stack at once; no
// clearing pass is needed, as a low-water mark stands in for the
// never-written stack entries.
module indexed_list_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ile_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ile_pkg::t_out o_out_data
);
    import ile_pkg::*;

    t_uop    uop;
    t_dp_sts sts;

    ile_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_uop      (uop)
    );

    ile_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (uop),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.count <= CNT_W'(LIST_CAP)))
        else $error("count beyond capacity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_EMPTY)) |-> (o_out_data.count == '0))
        else $error("empty status with nonzero count");

    a_err_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |-> (o_out_data.read_value == '0))
        else $error("read value on failed transaction");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while busy");

endmodule

// ===== sv/ile_ctrl.sv =====
module ile_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ile_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output ile_pkg::t_uop    o_uop
);
    import ile_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.err) begin
                    n_state = S_RDH;
                end else begin
                    case (i_sts.op)
                        OP_APPEND, OP_PREPEND: n_state = S_POP_RD;
                        OP_DEL_LAST, OP_DEL_FIRST, OP_GET, OP_SET,
                        OP_INSERT, OP_DELETE_AT: n_state = S_WALK;
                        OP_REVERSE: n_state = i_sts.len_lt2 ? S_RDH : S_REV;
                        default: n_state = S_RDH;
                    endcase
                end
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    case (i_sts.op)
                        OP_DEL_LAST:  n_state = i_sts.len_one ? S_DELF : S_DELL;
                        OP_DEL_FIRST: n_state = S_DELF;
                        OP_GET:       n_state = S_GET_A;
                        OP_SET:       n_state = S_SET;
                        OP_INSERT:    n_state = S_POP_RD;
                        OP_DELETE_AT: n_state = i_sts.pos_zero ? S_DELF :
                                                (i_sts.pos_last ? S_DELL : S_DM_A);
                        default:      n_state = S_RDH;
                    endcase
                end
            end
            S_POP_RD: n_state = S_POP_TAKE;
            S_POP_TAKE: begin
                case (i_sts.op)
                    OP_APPEND:  n_state = S_APPEND;
                    OP_PREPEND: n_state = S_PREPEND;
                    OP_INSERT:  n_state = i_sts.pos_zero ? S_PREPEND :
                                          (i_sts.pos_eq_len ? S_APPEND : S_INS_A);
                    default:    n_state = S_RDH;
                endcase
            end
            S_INS_A:   n_state = S_INS_B;
            S_DM_A:    n_state = S_DM_B;
            S_GET_A:   n_state = S_GET_B;
            S_REV:     n_state = i_sts.rev_last ? S_REV_END : S_REV;
            S_APPEND, S_PREPEND, S_INS_B, S_DELF, S_DELL, S_DM_B, S_GET_B,
            S_SET, S_REV_END: n_state = S_RDH;
            S_RDH:     n_state = S_RDT;
            S_RDT:     n_state = S_RDE;
            S_RDE:     n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE:     o_uop = i_in_valid ? U_LATCH : U_NONE;
            S_DISP:     o_uop = U_SETUP;
            S_WALK:     o_uop = i_sts.walk_done ? U_NONE : U_STEP;
            S_POP_RD:   o_uop = U_POP_RD;
            S_POP_TAKE: o_uop = U_POP_TAKE;
            S_APPEND:   o_uop = U_APPEND;
            S_PREPEND:  o_uop = U_PREPEND;
            S_INS_A:    o_uop = U_INS_A;
            S_INS_B:    o_uop = U_INS_B;
            S_DELF:     o_uop = U_DELF;
            S_DELL:     o_uop = U_DELL;
            S_DM_A:     o_uop = U_DM_A;
            S_DM_B:     o_uop = U_DM_B;
            S_GET_A:    o_uop = U_GET_A;
            S_GET_B:    o_uop = U_GET_B;
            S_SET:      o_uop = U_SET;
            S_REV:      o_uop = U_REV;
            S_REV_END:  o_uop = U_REV_END;
            S_RDH:      o_uop = U_RDH;
            S_RDT:      o_uop = U_RDT;
            S_RDE:      o_uop = U_RDE;
            S_EMIT:     o_uop = i_sts.out_free ? U_EMIT : U_NONE;
            default:    o_uop = U_NONE;
        endcase
    end

endmodule

// ===== sv/ile_dp.sv =====
module ile_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ile_pkg::t_uop     i_uop,
    input  ile_pkg::t_in      i_in_data,
    input  logic              i_out_ready,
    output ile_pkg::t_dp_sts  o_sts,
    output logic              o_out_valid,
    output ile_pkg::t_out     o_out_data
);
    import ile_pkg::*;

    logic [SLOT_W-1:0] link_mem [LIST_CAP];
    logic [VAL_W-1:0]  val_mem  [LIST_CAP];
    logic [SLOT_W-1:0] fs_mem   [LIST_CAP];

    logic [SLOT_W-1:0] link_q;
    logic [VAL_W-1:0]  val_q;
    logic [SLOT_W-1:0] fs_q;

    logic [OP_W-1:0]   r_op;
    logic [CNT_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;
    logic [SLOT_W-1:0] r_head, r_tail, r_cur, r_prev, r_s;
    logic [CNT_W-1:0]  r_len, r_fc, r_mark, r_k, r_tgt;
    logic [ST_W-1:0]   r_status;
    logic [VAL_W-1:0]  r_rd, r_hv, r_tv;
    logic              r_out_valid;
    t_out              r_out;

    logic [CNT_W-1:0]  fcm1;
    logic              full;
    logic [ST_W-1:0]   err_code;
    logic [CNT_W-1:0]  tgt_c;

    logic              lw_en, vw_en, push;
    logic [SLOT_W-1:0] lw_addr, lw_data, lr_addr, vw_addr, vr_addr, push_slot;
    logic [VAL_W-1:0]  vw_data;

    assign fcm1 = r_fc - CNT_W'(1);
    assign full = (r_len >= CNT_W'(LIST_CAP)) || (r_fc == '0);

    always_comb begin
        err_code = ST_OK;
        tgt_c    = '0;
        case (r_op)
            OP_APPEND, OP_PREPEND: begin
                if (full) err_code = ST_FULL;
            end
            OP_DEL_LAST: begin
                if (r_len == '0) err_code = ST_EMPTY;
                if (r_len >= CNT_W'(2)) tgt_c = r_len - CNT_W'(2);
            end
            OP_DEL_FIRST: begin
                if (r_len == '0) err_code = ST_EMPTY;
            end
            OP_GET, OP_SET: begin
                if (r_pos >= r_len) err_code = ST_BADIDX;
                tgt_c = r_pos;
            end
            OP_INSERT: begin
                if (r_pos > r_len) err_code = ST_BADIDX;
                else if (full) err_code = ST_FULL;
                if (r_pos != '0) tgt_c = r_pos - CNT_W'(1);
            end
            OP_DELETE_AT: begin
                if (r_pos >= r_len) err_code = ST_BADIDX;
                if (r_pos != '0) tgt_c = r_pos - CNT_W'(1);
            end
            default: ;
        endcase
    end

    assign o_sts.op         = r_op;
    assign o_sts.err        = (err_code != ST_OK);
    assign o_sts.walk_done  = (r_k == r_tgt);
    assign o_sts.rev_last   = ((r_k + CNT_W'(1)) == r_len);
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.pos_eq_len = (r_pos == r_len);
    assign o_sts.pos_last   = ((r_pos + CNT_W'(1)) == r_len);
    assign o_sts.len_one    = (r_len == CNT_W'(1));
    assign o_sts.len_lt2    = (r_len < CNT_W'(2));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        lr_addr   = r_cur;
        vr_addr   = r_head;
        lw_en     = 1'b0;
        lw_addr   = r_cur;
        lw_data   = r_s;
        vw_en     = 1'b0;
        vw_addr   = r_s;
        vw_data   = r_val;
        push      = 1'b0;
        push_slot = r_cur;
        case (i_uop)
            U_SETUP: lr_addr = r_head;
            U_STEP:  lr_addr = link_q;
            U_APPEND: begin
                vw_en   = 1'b1;
                lw_en   = (r_len != '0);
                lw_addr = r_tail;
            end
            U_PREPEND: begin
                vw_en   = 1'b1;
                lw_en   = (r_len != '0);
                lw_addr = r_s;
                lw_data = r_head;
            end
            U_INS_A: begin
                vw_en   = 1'b1;
                lw_en   = 1'b1;
                lw_addr = r_s;
                lw_data = link_q;
            end
            U_INS_B: lw_en = 1'b1;
            U_DELF: begin
                push      = 1'b1;
                push_slot = r_head;
            end
            U_DELL: begin
                push      = 1'b1;
                push_slot = r_tail;
            end
            U_DM_A: lr_addr = link_q;
            U_DM_B: begin
                lw_en     = 1'b1;
                lw_data   = link_q;
                push      = 1'b1;
                push_slot = r_s;
            end
            U_GET_A: vr_addr = r_cur;
            U_SET: begin
                vw_en   = 1'b1;
                vw_addr = r_cur;
            end
            U_REV: begin
                lw_en   = 1'b1;
                lw_data = r_prev;
                lr_addr = link_q;
            end
            U_RDT: vr_addr = r_tail;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lw_en) link_mem[lw_addr] <= lw_data;
        link_q <= link_mem[lr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vw_en) val_mem[vw_addr] <= vw_data;
        val_q <= val_mem[vr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (push && (r_fc < CNT_W'(LIST_CAP))) fs_mem[r_fc[SLOT_W-1:0]] <= push_slot;
        fs_q <= fs_mem[fcm1[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_len       <= '0;
            r_fc        <= CNT_W'(LIST_CAP);
            r_mark      <= CNT_W'(LIST_CAP);
            r_out_valid <= 1'b0;
        end else begin
            if (push && (r_fc < CNT_W'(LIST_CAP))) r_fc <= r_fc + CNT_W'(1);
            case (i_uop)
                U_POP_TAKE: begin
                    r_fc <= fcm1;
                    if (fcm1 < r_mark) r_mark <= fcm1;
                end
                U_APPEND: begin
                    if (r_len == '0) r_head <= r_s;
                    r_tail <= r_s;
                    r_len  <= r_len + CNT_W'(1);
                end
                U_PREPEND: begin
                    if (r_len == '0) r_tail <= r_s;
                    r_head <= r_s;
                    r_len  <= r_len + CNT_W'(1);
                end
                U_INS_B: r_len <= r_len + CNT_W'(1);
                U_DELF: begin
                    r_len <= r_len - CNT_W'(1);
                    if (r_len == CNT_W'(1)) begin
                        r_head <= '0;
                        r_tail <= '0;
                    end else begin
                        r_head <= link_q;
                    end
                end
                U_DELL: begin
                    r_tail <= r_cur;
                    r_len  <= r_len - CNT_W'(1);
                end
                U_DM_B: r_len <= r_len - CNT_W'(1);
                U_REV_END: begin
                    r_head <= r_tail;
                    r_tail <= r_head;
                end
                default: ;
            endcase
            if (i_uop == U_EMIT) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_uop)
            U_LATCH: begin
                r_op  <= i_in_data.op;
                r_pos <= i_in_data.position;
                r_val <= i_in_data.item_value;
                r_rd  <= '0;
            end
            U_SETUP: begin
                r_cur    <= r_head;
                r_prev   <= '0;
                r_k      <= '0;
                r_tgt    <= tgt_c;
                r_status <= err_code;
            end
            U_STEP: begin
                r_cur <= link_q;
                r_k   <= r_k + CNT_W'(1);
            end
            U_POP_TAKE: r_s <= (fcm1 < r_mark) ? fcm1[SLOT_W-1:0] : fs_q;
            U_DM_A:     r_s <= link_q;
            U_GET_B:    r_rd <= val_q;
            U_REV: begin
                r_prev <= r_cur;
                r_cur  <= link_q;
                r_k    <= r_k + CNT_W'(1);
            end
            U_RDT: r_hv <= val_q;
            U_RDE: r_tv <= val_q;
            U_EMIT: begin
                r_out.status      <= r_status;
                r_out.read_value  <= r_rd;
                r_out.count       <= r_len;
                r_out.first_value <= (r_len == '0) ? '0 : r_hv;
                r_out.last_value  <= (r_len == '0) ? '0 : r_tv;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
